@@ sv/spi_crc8_register_access_retry_macros.svh @@
// Assertion macros for the SPI CRC-8 register access sequencer.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef SPI_CRC8_REGISTER_ACCESS_RETRY_MACROS_SVH
`define SPI_CRC8_REGISTER_ACCESS_RETRY_MACROS_SVH

// checked only while out of reset
`define SCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scf assertion failed");

// checked on every edge, reset included
`define SCF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scf assertion failed");

`endif

@@ sv/scf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the SPI CRC-8 register access sequencer: widths, codes,
// queue item and status types, CRC-8 function. No dependencies.
package scf_pkg;

  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int RETRY_W = 4;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd10;
  localparam logic [BYTE_W-1:0]  CRC_POLY        = 8'h07;
  localparam logic [BYTE_W-1:0]  READ_FILL       = 8'hFF;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESP  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RESP  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_RESENT = 3'b100
  } phase_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] reg_address;
    logic [BYTE_W-1:0] write_data;
    logic              last_byte;
    logic [BYTE_W-1:0] rx_first_byte;
    logic [BYTE_W-1:0] rx_second_byte;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // one byte through the MSB-first CRC-8 register
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ sv/scf_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request/response input, result output,
// configuration write. Depends on scf_pkg.
interface scf_in_if;
  import scf_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] reg_address;
  logic [BYTE_W-1:0] write_data;
  logic              last_byte;
  logic [BYTE_W-1:0] rx_first_byte;
  logic [BYTE_W-1:0] rx_second_byte;
  modport source (output valid, mode, reg_address, write_data, last_byte,
                  rx_first_byte, rx_second_byte, input ready);
  modport sink   (input valid, mode, reg_address, write_data, last_byte,
                  rx_first_byte, rx_second_byte, output ready);
endinterface

interface scf_out_if;
  import scf_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] tx_address_byte;
  logic [BYTE_W-1:0] tx_data_byte;
  logic [BYTE_W-1:0] tx_crc;
  logic              pause_before;
  logic              status;
  logic [BYTE_W-1:0] read_data;
  logic              last_of_burst;
  modport source (output valid, kind, tx_address_byte, tx_data_byte, tx_crc,
                  pause_before, status, read_data, last_of_burst, input ready);
  modport sink   (input valid, kind, tx_address_byte, tx_data_byte, tx_crc,
                  pause_before, status, read_data, last_of_burst, output ready);
endinterface

interface scf_cfg_if;
  import scf_pkg::*;
  logic               valid;
  logic               ready;
  logic [RETRY_W-1:0] max_retries;
  modport source (output valid, max_retries, input ready);
  modport sink   (input valid, max_retries, output ready);
endinterface

@@ sv/spi_crc8_register_access_retry.sv @@
`timescale 1ns / 1ps
// Flow: an accepted item is written into the queue, popped by the back end,
// and its result, if any, is registered on the output.
// Throughput: one item per cycle while the output is not stalled.
// Reset: synchronous, active low; clears sequencer state, queue and output
// valid, and sets the retry limit to 10. Depends on scf_pkg, scf_ifs, macros.
module spi_crc8_register_access_retry #(
  parameter int QUEUE_DEPTH = scf_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  scf_in_if.sink    in_chan,
  scf_out_if.source out_chan,
  scf_cfg_if.sink   cfg_chan
);
  import scf_pkg::*;
  `include "spi_crc8_register_access_retry_macros.svh"

  queue_stat_t q_stat;
  item_t       push_item, pop_item;
  logic        push, pop;

  scf_front u_front (
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  scf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_stat    (q_stat),
    .pop_item  (pop_item)
  );

  scf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .q_stat   (q_stat),
    .pop_item (pop_item),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `SCF_ASSERT(a_no_push_full, push |-> !q_stat.full)
  `SCF_ASSERT(a_no_pop_empty, pop |-> !q_stat.empty)
  `SCF_ASSERT(a_pop_when_room, pop |-> (!out_chan.valid || out_chan.ready))
  `SCF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_chan.valid)

endmodule

@@ sv/scf_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input items, drops unused mode codes, tags the rest
// with an op code for the queue. Depends on scf_pkg and scf_ifs.
module scf_front (
  scf_in_if.sink              in_chan,
  input  scf_pkg::queue_stat_t q_stat,
  output logic                push,
  output scf_pkg::item_t      push_item
);
  import scf_pkg::*;

  logic keep;

  assign in_chan.ready = !q_stat.full;

  always_comb begin
    keep         = 1'b1;
    push_item.op = OP_RESP;
    unique case (in_chan.mode)
      MODE_WRITE: push_item.op = OP_WRITE;
      MODE_READ:  push_item.op = OP_READ;
      MODE_RESP:  push_item.op = OP_RESP;
      default:    keep         = 1'b0;
    endcase
    push_item.reg_address    = in_chan.reg_address;
    push_item.write_data     = in_chan.write_data;
    push_item.last_byte      = in_chan.last_byte;
    push_item.rx_first_byte  = in_chan.rx_first_byte;
    push_item.rx_second_byte = in_chan.rx_second_byte;
  end

  assign push = in_chan.valid && in_chan.ready && keep;

endmodule

@@ sv/scf_queue.sv @@
`timescale 1ns / 1ps
// Short item queue between front and back end, register based.
// Depends on scf_pkg.
module scf_queue #(
  parameter int DEPTH = scf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  scf_pkg::item_t       push_item,
  input  logic                 pop,
  output scf_pkg::queue_stat_t q_stat,
  output scf_pkg::item_t       pop_item
);
  import scf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign pop_item     = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/scf_back.sv @@
`timescale 1ns / 1ps
// Back end: byte/retry sequencer state, frame and CRC build, registered
// result output, retry limit register. Depends on scf_pkg and scf_ifs.
module scf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  scf_cfg_if.sink              cfg_chan,
  input  scf_pkg::queue_stat_t q_stat,
  input  scf_pkg::item_t       pop_item,
  output logic                 pop,
  scf_out_if.source            out_chan
);
  import scf_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [ADDR_W-1:0]  next_addr_r, next_addr_nxt;
  logic [BYTE_W-1:0]  held_data_r, held_data_nxt;
  logic               is_read_r, is_read_nxt;
  logic [RETRY_W-1:0] retries_r, retries_nxt;
  logic               in_burst_r, in_burst_nxt;
  logic               held_last_r, held_last_nxt;
  logic [RETRY_W-1:0] max_retries_r;

  logic               out_valid_r;
  logic               kind_r, pause_r, status_r, last_r;
  logic [BYTE_W-1:0]  tx_addr_r, tx_data_r, tx_crc_r, read_data_r;

  logic               can_take;
  logic               has_res, done, pause, done_status, match;
  logic [BYTE_W-1:0]  done_rd;
  logic [RETRY_W-1:0] retries_dec;
  logic [BYTE_W-1:0]  frame_a, frame_d, frame_crc;

  assign can_take      = !out_valid_r || out_chan.ready;
  assign pop           = !q_stat.empty && can_take;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    next_addr_nxt = next_addr_r;
    held_data_nxt = held_data_r;
    is_read_nxt   = is_read_r;
    retries_nxt   = retries_r;
    in_burst_nxt  = in_burst_r;
    held_last_nxt = held_last_r;
    has_res       = 1'b0;
    done          = 1'b0;
    pause         = 1'b1;
    done_status   = 1'b1;
    done_rd       = '0;
    match         = 1'b0;
    retries_dec   = (retries_r != '0) ? retries_r - 1'b1 : '0;
    if (pop) begin
      unique case (pop_item.op)
        OP_WRITE, OP_READ: begin
          if (phase_r == PH_IDLE) begin
            if (!in_burst_r) begin
              next_addr_nxt = pop_item.reg_address;
            end
            pause         = in_burst_r;
            is_read_nxt   = (pop_item.op == OP_READ);
            held_data_nxt = pop_item.write_data;
            held_last_nxt = pop_item.last_byte;
            retries_nxt   = max_retries_r;
            in_burst_nxt  = 1'b1;
            phase_nxt     = PH_FIRST;
            has_res       = 1'b1;
          end
        end
        OP_RESP: begin
          unique case (phase_r)
            PH_FIRST: begin
              if (retries_r != '0) begin
                phase_nxt = PH_RESENT;
                has_res   = 1'b1;
              end else begin
                done = 1'b1;
              end
            end
            PH_RESENT: begin
              match = (pop_item.rx_first_byte == {~is_read_r, next_addr_r}) &&
                      (is_read_r || (pop_item.rx_second_byte == held_data_r));
              retries_nxt = retries_dec;
              if (match) begin
                done        = 1'b1;
                done_status = 1'b0;
                done_rd     = is_read_r ? pop_item.rx_second_byte : '0;
              end else if (retries_dec != '0) begin
                has_res = 1'b1;
              end else begin
                done = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (done) begin
      has_res       = 1'b1;
      next_addr_nxt = next_addr_r + 1'b1;
      in_burst_nxt  = !held_last_r;
      phase_nxt     = PH_IDLE;
    end
  end

  assign frame_a   = {~is_read_nxt, next_addr_nxt};
  assign frame_d   = is_read_nxt ? READ_FILL : held_data_nxt;
  assign frame_crc = crc8_byte(crc8_byte('0, frame_a), frame_d);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      next_addr_r   <= '0;
      held_data_r   <= '0;
      is_read_r     <= 1'b0;
      retries_r     <= '0;
      in_burst_r    <= 1'b0;
      held_last_r   <= 1'b0;
      max_retries_r <= MAX_RETRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      next_addr_r <= next_addr_nxt;
      held_data_r <= held_data_nxt;
      is_read_r   <= is_read_nxt;
      retries_r   <= retries_nxt;
      in_burst_r  <= in_burst_nxt;
      held_last_r <= held_last_nxt;
      if (cfg_chan.valid) begin
        max_retries_r <= cfg_chan.max_retries;
      end
      if (can_take) begin
        out_valid_r <= has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && has_res) begin
      kind_r      <= done;
      tx_addr_r   <= done ? '0 : frame_a;
      tx_data_r   <= done ? '0 : frame_d;
      tx_crc_r    <= done ? '0 : frame_crc;
      pause_r     <= !done && pause;
      status_r    <= done && done_status;
      read_data_r <= done_rd;
      last_r      <= done && held_last_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.kind            = kind_r;
  assign out_chan.tx_address_byte = tx_addr_r;
  assign out_chan.tx_data_byte    = tx_data_r;
  assign out_chan.tx_crc          = tx_crc_r;
  assign out_chan.pause_before    = pause_r;
  assign out_chan.status          = status_r;
  assign out_chan.read_data       = read_data_r;
  assign out_chan.last_of_burst   = last_r;

endmodule

@@ verif/spi_crc8_register_access_retry_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the SPI CRC-8 register access sequencer: directed bursts,
// retry limits and ignored items, then random traffic checked against a built-in model.
// Depends on scf_pkg, scf_ifs and the spi_crc8_register_access_retry RTL.
module spi_crc8_register_access_retry_test;
  import scf_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 400;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] reg_address;
    logic [BYTE_W-1:0] write_data;
    logic              last_byte;
    logic [BYTE_W-1:0] rx_first_byte;
    logic [BYTE_W-1:0] rx_second_byte;
  } seq_req_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] tx_address_byte;
    logic [BYTE_W-1:0] tx_data_byte;
    logic [BYTE_W-1:0] tx_crc;
    logic              pause_before;
    logic              status;
    logic [BYTE_W-1:0] read_data;
    logic              last_of_burst;
  } seq_result_t;

  logic clk;
  logic rst_n;

  scf_in_if  in_chan();
  scf_out_if out_chan();
  scf_cfg_if cfg_chan();

  spi_crc8_register_access_retry DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // sequencer model state
  phase_t             seq_phase;
  logic [ADDR_W-1:0]  seq_addr;
  logic [BYTE_W-1:0]  seq_data;
  logic               seq_read;
  logic [RETRY_W-1:0] seq_retries;
  logic [RETRY_W-1:0] seq_limit;
  logic               seq_burst;
  logic               seq_last;

  seq_result_t pending_results[$];
  int          mismatches;
  int          act_count;
  int          quiet_cycles;
  bit          idle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] frame_addr();
    return {~seq_read, seq_addr};
  endfunction

  function automatic logic [BYTE_W-1:0] frame_data();
    return seq_read ? READ_FILL : seq_data;
  endfunction

  // bit-serial CRC-8 over the address and data bytes, init 0
  function automatic logic [BYTE_W-1:0] crc8_pair(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] d);
    logic [2*BYTE_W-1:0] msg;
    logic [BYTE_W-1:0]   c;
    logic                fb;
    msg = {a, d};
    c = '0;
    for (int i = 2*BYTE_W-1; i >= 0; i--) begin
      fb = c[BYTE_W-1] ^ msg[i];
      c = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic push_frame(input logic pause_bit);
    seq_result_t e;
    e = '0;
    e.tx_address_byte = frame_addr();
    e.tx_data_byte    = frame_data();
    e.tx_crc          = crc8_pair(frame_addr(), frame_data());
    e.pause_before    = pause_bit;
    pending_results.push_back(e);
    act_count++;
  endtask

  task automatic push_done(input logic stat, input logic [BYTE_W-1:0] rd);
    seq_result_t e;
    e = '0;
    e.kind          = 1'b1;
    e.status        = stat;
    e.read_data     = rd;
    e.last_of_burst = seq_last;
    pending_results.push_back(e);
    act_count++;
    seq_addr  = seq_addr + 1'b1;
    seq_burst = ~seq_last;
    seq_phase = PH_IDLE;
  endtask

  task automatic predict(input seq_req_t r);
    logic hit;
    if (r.mode == MODE_WRITE || r.mode == MODE_READ) begin
      if (seq_phase == PH_IDLE) begin
        if (!seq_burst) seq_addr = r.reg_address;
        seq_read    = (r.mode == MODE_READ);
        seq_data    = r.write_data;
        seq_last    = r.last_byte;
        seq_retries = seq_limit;
        seq_phase   = PH_FIRST;
        push_frame(seq_burst);
        seq_burst   = 1'b1;
      end
    end else if (r.mode == MODE_RESP) begin
      if (seq_phase == PH_FIRST) begin
        if (seq_retries != 0) begin
          seq_phase = PH_RESENT;
          push_frame(1'b1);
        end else begin
          push_done(1'b1, 8'h00);
        end
      end else if (seq_phase == PH_RESENT) begin
        hit = (r.rx_first_byte == frame_addr()) &&
              (seq_read || r.rx_second_byte == seq_data);
        if (seq_retries != 0) seq_retries = seq_retries - 1'b1;
        if (hit) push_done(1'b0, seq_read ? r.rx_second_byte : 8'h00);
        else if (seq_retries != 0) push_frame(1'b1);
        else push_done(1'b1, 8'h00);
      end
    end
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic last,
                           input logic [BYTE_W-1:0] rx0, input logic [BYTE_W-1:0] rx1);
    seq_req_t r;
    r = '{mode, addr, data, last, rx0, rx1};
    in_chan.valid          <= 1'b1;
    in_chan.mode           <= mode;
    in_chan.reg_address    <= addr;
    in_chan.write_data     <= data;
    in_chan.last_byte      <= last;
    in_chan.rx_first_byte  <= rx0;
    in_chan.rx_second_byte <= rx1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict(r);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_retry_limit(input logic [RETRY_W-1:0] v);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.max_retries <= v;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    seq_limit = v;
    cfg_chan.valid <= 1'b0;
  endtask

  // one byte: request, then responses until it finishes
  task automatic run_access(input logic rd, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] data, input logic last);
    int                hit_pct;
    logic [BYTE_W-1:0] rx0;
    logic [BYTE_W-1:0] rx1;
    hit_pct = ($urandom_range(0, 3) == 0) ? 5 : 50;
    send_item(rd ? MODE_READ : MODE_WRITE, addr, data, last,
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 9) == 0)
        send_item($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0)
        send_item(MODE_UNUSED, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      rx0 = 8'($urandom_range(0, 255));
      rx1 = 8'($urandom_range(0, 255));
      if (seq_phase == PH_RESENT) begin
        if ($urandom_range(0, 99) < hit_pct) begin
          rx0 = frame_addr();
          if (!seq_read) rx1 = seq_data;
        end else if (!seq_read && $urandom_range(0, 1) == 1) begin
          rx0 = frame_addr();
          rx1 = seq_data ^ 8'($urandom_range(1, 255));
        end else begin
          rx0 = frame_addr() ^ (8'd1 << $urandom_range(0, 7));
        end
      end
      send_item(MODE_RESP, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), rx0, rx1);
    end
  endtask

  task automatic run_burst();
    int                len;
    logic [ADDR_W-1:0] addr;
    len  = $urandom_range(1, 4);
    addr = 7'($urandom_range(0, 127));
    for (int i = 0; i < len; i++) begin
      // occasionally leave the burst open
      if (i == len - 1 && $urandom_range(0, 11) == 0) break;
      run_access(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic run_phase(input logic [RETRY_W-1:0] limit, input bit idling, input int n);
    int start;
    drain_results();
    write_retry_limit(limit);
    idle_en = idling;
    start = act_count;
    while (act_count - start < n) begin
      if ($urandom_range(0, 99) < 85) run_burst();
      else send_item(MODE_W'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  // write at 0x7F, read wrapping to 0x00, write of 0xFF with a data-only miss
  task automatic test_write_read_burst();
    send_item(MODE_WRITE, 7'h7F, 8'h00, 1'b0, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, 8'hFF, 8'hFF);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, frame_addr(), seq_data);
    send_item(MODE_READ, 7'h55, 8'hAA, 1'b0, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h7F, 8'hFF, 1'b1, frame_addr(), 8'hA5);
    send_item(MODE_WRITE, 7'h00, 8'hFF, 1'b1, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, frame_addr(), 8'hFE);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, frame_addr(), 8'hFF);
  endtask

  // response while idle, unused mode, request while busy
  task automatic test_ignored_items();
    send_item(MODE_RESP, 7'h7F, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    send_item(MODE_UNUSED, 7'h7F, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    send_item(MODE_READ, 7'h00, 8'h00, 1'b1, 8'h00, 8'h00);
    send_item(MODE_WRITE, 7'h12, 8'h34, 1'b0, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, frame_addr() ^ 8'h80, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, frame_addr(), 8'h3C);
  endtask

  // zero retries ends after the ignored response; one retry ends on a single miss
  task automatic test_retry_limits();
    drain_results();
    write_retry_limit(4'd0);
    send_item(MODE_WRITE, 7'h40, 8'h5A, 1'b1, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, frame_addr(), seq_data);
    drain_results();
    write_retry_limit(4'd1);
    send_item(MODE_READ, 7'h21, 8'h00, 1'b1, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, 8'h00, 8'h00);
    send_item(MODE_RESP, 7'h00, 8'h00, 1'b0, frame_addr() ^ 8'h01, 8'h00);
  endtask

  task automatic test_random_traffic();
    run_phase(4'd15, 1'b1, 70);
    run_phase(4'd1, 1'b1, 50);
    run_phase(4'd0, 1'b1, 30);
    run_phase(RETRY_W'($urandom_range(2, 14)), 1'b1, 70);
  endtask

  // sender holds off until every expected result is back, then resumes
  task automatic test_drain_pressure();
    int start;
    run_phase(4'd3, 1'b1, 30);
    drain_results();
    start = act_count;
    while (act_count - start < 30) run_burst();
  endtask

  task automatic test_unthrottled();
    run_phase(4'd10, 1'b0, 100);
  endtask

  initial begin
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.mode           <= MODE_WRITE;
    in_chan.reg_address    <= '0;
    in_chan.write_data     <= '0;
    in_chan.last_byte      <= 1'b0;
    in_chan.rx_first_byte  <= '0;
    in_chan.rx_second_byte <= '0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.max_retries   <= '0;
    seq_phase   = PH_IDLE;
    seq_addr    = '0;
    seq_data    = '0;
    seq_read    = 1'b0;
    seq_retries = '0;
    seq_limit   = MAX_RETRIES_RST;
    seq_burst   = 1'b0;
    seq_last    = 1'b0;
    mismatches  = 0;
    act_count   = 0;
    idle_en     = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_write_read_burst();
    test_ignored_items();
    test_retry_limits();
    test_random_traffic();
    test_drain_pressure();
    test_unthrottled();
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("spi_crc8_register_access_retry verification clean");
    end else begin
      $display("spi_crc8_register_access_retry verification failed");
    end
    $finish;
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    seq_result_t got;
    seq_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.kind, out_chan.tx_address_byte, out_chan.tx_data_byte, out_chan.tx_crc,
              out_chan.pause_before, out_chan.status, out_chan.read_data,
              out_chan.last_of_burst};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item at %0t: kind=%0d addr=%02h data=%02h crc=%02h", $time,
                   got.kind, got.tx_address_byte, got.tx_data_byte, got.tx_crc);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.tx_address_byte !== want.tx_address_byte ||
            got.tx_data_byte !== want.tx_data_byte || got.tx_crc !== want.tx_crc ||
            got.pause_before !== want.pause_before || got.status !== want.status ||
            got.read_data !== want.read_data || got.last_of_burst !== want.last_of_burst) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp kind=%0d addr=%02h data=%02h crc=%02h pause=%0d",
                     $time, want.kind, want.tx_address_byte, want.tx_data_byte, want.tx_crc,
                     want.pause_before);
            $display("  exp status=%0d rd=%02h last=%0d", want.status, want.read_data,
                     want.last_of_burst);
            $display("  got kind=%0d addr=%02h data=%02h crc=%02h pause=%0d", got.kind,
                     got.tx_address_byte, got.tx_data_byte, got.tx_crc, got.pause_before);
            $display("  got status=%0d rd=%02h last=%0d", got.status, got.read_data,
                     got.last_of_burst);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
                 (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("spi_crc8_register_access_retry verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
